[rtl/mfs_pkg.sv]
// Shared types, codes and constants of the multilevel feedback scheduler.
package mfs_pkg;

    localparam int LEVELS    = 3;
    localparam int MAX_TASKS = 16;
    localparam int TASK_W    = 4;
    localparam int TIME_W    = 16;
    localparam int LEVEL_W   = 2;
    localparam int STATUS_W  = 3;
    localparam int APB_AW    = 4;
    localparam int APB_DW    = 32;

    typedef logic [TASK_W-1:0]  task_id_t;
    typedef logic [TIME_W-1:0]  time_t;
    typedef logic [LEVEL_W-1:0] level_t;

    localparam level_t LVL_TOP    = 2'd0;
    localparam level_t LVL_MIDDLE = 2'd1;
    localparam level_t LVL_BOTTOM = 2'd2;

    localparam logic KIND_ADMIT    = 1'b0;
    localparam logic KIND_DISPATCH = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_ADMITTED   = 3'd0,
        ST_DISPATCHED = 3'd1,
        ST_FULL       = 3'd2,
        ST_NO_TASK    = 3'd3,
        ST_BAD_LEVEL  = 3'd4
    } status_t;

    localparam logic [1:0] REG_QUANTUM_TOP    = 2'd0;
    localparam logic [1:0] REG_QUANTUM_MIDDLE = 2'd1;
    localparam logic [1:0] REG_QUANTUM_BOTTOM = 2'd2;

    localparam time_t QUANTUM_TOP_RESET    = 16'd4;
    localparam time_t QUANTUM_MIDDLE_RESET = 16'd8;
    localparam time_t QUANTUM_BOTTOM_RESET = 16'd16;

    typedef struct packed {
        logic     pop;
        level_t   pop_level;
        logic     push;
        level_t   push_level;
        task_id_t push_id;
    } queue_cmd_t;

    typedef struct packed {
        logic [LEVELS-1:0]    nonempty;
        logic [LEVELS-1:0]    full;
        task_id_t [LEVELS-1:0] head_id;
    } queue_stat_t;

    typedef struct packed {
        logic     wr_en;
        task_id_t wr_id;
        time_t    wr_time;
        task_id_t rd_id;
    } time_cmd_t;

endpackage

[rtl/mfs_cfg_regs.sv]
// APB register block holding the quantum of each scheduler level.
module mfs_cfg_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mfs_pkg::APB_AW-1:0]        paddr,
    input  logic [mfs_pkg::APB_DW-1:0]        pwdata,
    output logic [mfs_pkg::APB_DW-1:0]        prdata,
    output logic                              pready,
    output mfs_pkg::time_t [mfs_pkg::LEVELS-1:0] quantum
);

    mfs_pkg::time_t quantum_reg [mfs_pkg::LEVELS];
    logic [1:0]     reg_index;
    logic           wr_strobe;

    assign reg_index = paddr[3:2];
    assign wr_strobe = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quantum_reg[0] <= mfs_pkg::QUANTUM_TOP_RESET;
            quantum_reg[1] <= mfs_pkg::QUANTUM_MIDDLE_RESET;
            quantum_reg[2] <= mfs_pkg::QUANTUM_BOTTOM_RESET;
        end else if (wr_strobe) begin
            unique case (reg_index)
                mfs_pkg::REG_QUANTUM_TOP:    quantum_reg[0] <= pwdata[mfs_pkg::TIME_W-1:0];
                mfs_pkg::REG_QUANTUM_MIDDLE: quantum_reg[1] <= pwdata[mfs_pkg::TIME_W-1:0];
                mfs_pkg::REG_QUANTUM_BOTTOM: quantum_reg[2] <= pwdata[mfs_pkg::TIME_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_index)
            mfs_pkg::REG_QUANTUM_TOP:
                prdata = {{(mfs_pkg::APB_DW-mfs_pkg::TIME_W){1'b0}}, quantum_reg[0]};
            mfs_pkg::REG_QUANTUM_MIDDLE:
                prdata = {{(mfs_pkg::APB_DW-mfs_pkg::TIME_W){1'b0}}, quantum_reg[1]};
            mfs_pkg::REG_QUANTUM_BOTTOM:
                prdata = {{(mfs_pkg::APB_DW-mfs_pkg::TIME_W){1'b0}}, quantum_reg[2]};
            default:
                prdata = '0;
        endcase
    end

    assign quantum[0] = quantum_reg[0];
    assign quantum[1] = quantum_reg[1];
    assign quantum[2] = quantum_reg[2];

endmodule

[rtl/mfs_level_queues.sv]
// Three ring FIFOs of task ids, one per scheduler level.
module mfs_level_queues #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  mfs_pkg::queue_cmd_t  cmd,
    output mfs_pkg::queue_stat_t stat
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    mfs_pkg::task_id_t ring_reg [mfs_pkg::LEVELS][QUEUE_DEPTH];
    logic [PTR_W-1:0]  head_reg  [mfs_pkg::LEVELS];
    logic [PTR_W-1:0]  tail_reg  [mfs_pkg::LEVELS];
    logic [CNT_W-1:0]  count_reg [mfs_pkg::LEVELS];
    logic [PTR_W-1:0]  head_next [mfs_pkg::LEVELS];
    logic [PTR_W-1:0]  tail_next [mfs_pkg::LEVELS];
    logic [CNT_W-1:0]  count_next [mfs_pkg::LEVELS];
    logic [mfs_pkg::LEVELS-1:0] pop_hit;
    logic [mfs_pkg::LEVELS-1:0] push_hit;

    for (genvar l = 0; l < mfs_pkg::LEVELS; l++) begin : g_level
        assign pop_hit[l]  = cmd.pop  && (cmd.pop_level  == mfs_pkg::LEVEL_W'(l));
        assign push_hit[l] = cmd.push && (cmd.push_level == mfs_pkg::LEVEL_W'(l));

        always_comb begin
            head_next[l]  = head_reg[l];
            tail_next[l]  = tail_reg[l];
            count_next[l] = count_reg[l];
            if (pop_hit[l]) begin
                head_next[l] = (head_reg[l] == PTR_LAST) ? '0 : head_reg[l] + 1'b1;
            end
            if (push_hit[l]) begin
                tail_next[l] = (tail_reg[l] == PTR_LAST) ? '0 : tail_reg[l] + 1'b1;
            end
            if (push_hit[l] && !pop_hit[l]) begin
                count_next[l] = count_reg[l] + 1'b1;
            end else if (pop_hit[l] && !push_hit[l]) begin
                count_next[l] = count_reg[l] - 1'b1;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                head_reg[l]  <= '0;
                tail_reg[l]  <= '0;
                count_reg[l] <= '0;
            end else begin
                head_reg[l]  <= head_next[l];
                tail_reg[l]  <= tail_next[l];
                count_reg[l] <= count_next[l];
            end
        end

        always_ff @(posedge aclk) begin
            if (push_hit[l]) begin
                ring_reg[l][tail_reg[l]] <= cmd.push_id;
            end
        end

        assign stat.nonempty[l] = (count_reg[l] != '0);
        assign stat.full[l]     = (count_reg[l] == CNT_FULL);
        assign stat.head_id[l]  = ring_reg[l][head_reg[l]];

`ifndef SYNTHESIS
        a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
            push_hit[l] && !pop_hit[l] |-> count_reg[l] != CNT_FULL)
            else $error("push into a full level");
        a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
            pop_hit[l] |-> count_reg[l] != '0)
            else $error("pop from an empty level");
`endif
    end

endmodule

[rtl/mfs_time_store.sv]
// Remaining run time of every task, written and read by task id.
module mfs_time_store (
    input  logic               aclk,
    input  mfs_pkg::time_cmd_t cmd,
    output mfs_pkg::time_t     rd_time
);

    mfs_pkg::time_t time_reg [mfs_pkg::MAX_TASKS];

    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            time_reg[cmd.wr_id] <= cmd.wr_time;
        end
    end

    assign rd_time = time_reg[cmd.rd_id];

endmodule

[rtl/multilevel_feedback_scheduler.sv]
// Top level of the three-level feedback scheduler with request and result channels.
//
//   Channel   Direction  Handshake           Payload
//   s_        in         s_valid / s_ready   kind, task_id, burst_time, start_level
//   m_        out        m_valid / m_ready   status, task, levels, times, flags
//   APB       in         psel / penable      quantum registers at 0x0, 0x4, 0x8
//
// Each request passes from acceptance into the input register, then through the pick, pop,
// subtract and push logic into the result register.
// A request is accepted in every cycle while results are taken.
// Reset is synchronous and active low; it empties all levels and restores the quanta.
// A stalled result holds the input register, which then holds s_ready low.
module multilevel_feedback_scheduler #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mfs_pkg::APB_AW-1:0]          paddr,
    input  logic [mfs_pkg::APB_DW-1:0]          pwdata,
    output logic [mfs_pkg::APB_DW-1:0]          prdata,
    output logic                                pready,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_kind,
    input  logic [mfs_pkg::TASK_W-1:0]          s_task_id,
    input  logic [mfs_pkg::TIME_W-1:0]          s_burst_time,
    input  logic [mfs_pkg::LEVEL_W-1:0]         s_start_level,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [mfs_pkg::STATUS_W-1:0]        m_status,
    output logic [mfs_pkg::TASK_W-1:0]          m_served_task,
    output logic [mfs_pkg::LEVEL_W-1:0]         m_served_level,
    output logic [mfs_pkg::TIME_W-1:0]          m_granted_time,
    output logic [mfs_pkg::TIME_W-1:0]          m_time_left,
    output logic                                m_finished,
    output logic [mfs_pkg::LEVEL_W-1:0]         m_next_level,
    output logic                                m_requeue_dropped
);

    mfs_pkg::time_t [mfs_pkg::LEVELS-1:0] quantum;
    mfs_pkg::queue_cmd_t  q_cmd;
    mfs_pkg::queue_stat_t q_stat;
    mfs_pkg::time_cmd_t   t_cmd;
    mfs_pkg::time_t       rd_time;

    logic              in_valid_reg;
    logic              in_kind_reg;
    mfs_pkg::task_id_t in_task_reg;
    mfs_pkg::time_t    in_burst_reg;
    mfs_pkg::level_t   in_level_reg;

    logic              out_valid_reg;
    mfs_pkg::status_t  status_reg, status_next;
    mfs_pkg::task_id_t task_reg, task_next;
    mfs_pkg::level_t   served_level_reg, served_level_next;
    mfs_pkg::time_t    granted_reg, granted_next;
    mfs_pkg::time_t    left_reg, left_next;
    logic              finished_reg, finished_next;
    mfs_pkg::level_t   next_level_reg, next_level_next;
    logic              dropped_reg, dropped_next;

    logic              advance;
    logic              in_take;
    logic [3:0]        full_by_level;
    mfs_pkg::level_t   pick_level;
    mfs_pkg::level_t   down_level;
    mfs_pkg::task_id_t pick_id;
    mfs_pkg::time_t    pick_quantum;
    logic              down_full;
    logic              fits;
    mfs_pkg::time_t    time_diff;

    mfs_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .quantum (quantum)
    );

    mfs_level_queues #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queues (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (q_cmd),
        .stat    (q_stat)
    );

    mfs_time_store u_times (
        .aclk    (aclk),
        .cmd     (t_cmd),
        .rd_time (rd_time)
    );

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign in_take = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_take) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_kind_reg  <= s_kind;
            in_task_reg  <= s_task_id;
            in_burst_reg <= s_burst_time;
            in_level_reg <= s_start_level;
        end
    end

    // The highest non-empty level wins; the bottom level is the fallback pick.
    always_comb begin
        priority if (q_stat.nonempty[0]) begin
            pick_level   = mfs_pkg::LVL_TOP;
            down_level   = mfs_pkg::LVL_MIDDLE;
            pick_id      = q_stat.head_id[0];
            pick_quantum = quantum[0];
            down_full    = q_stat.full[1];
        end else if (q_stat.nonempty[1]) begin
            pick_level   = mfs_pkg::LVL_MIDDLE;
            down_level   = mfs_pkg::LVL_BOTTOM;
            pick_id      = q_stat.head_id[1];
            pick_quantum = quantum[1];
            down_full    = q_stat.full[2];
        end else begin
            pick_level   = mfs_pkg::LVL_BOTTOM;
            down_level   = mfs_pkg::LVL_BOTTOM;
            pick_id      = q_stat.head_id[2];
            pick_quantum = quantum[2];
            down_full    = 1'b0;
        end
    end

    assign full_by_level = {1'b1, q_stat.full};
    assign fits          = (rd_time <= pick_quantum);
    assign time_diff     = rd_time - pick_quantum;

    always_comb begin
        status_next       = mfs_pkg::ST_ADMITTED;
        task_next         = '0;
        served_level_next = '0;
        granted_next      = '0;
        left_next         = '0;
        finished_next     = 1'b0;
        next_level_next   = '0;
        dropped_next      = 1'b0;
        q_cmd             = '0;
        t_cmd             = '0;
        t_cmd.rd_id       = pick_id;

        if (in_kind_reg == mfs_pkg::KIND_ADMIT) begin
            task_next = in_task_reg;
            if (in_level_reg > mfs_pkg::LVL_BOTTOM) begin
                status_next = mfs_pkg::ST_BAD_LEVEL;
            end else begin
                served_level_next = in_level_reg;
                if (full_by_level[in_level_reg]) begin
                    status_next = mfs_pkg::ST_FULL;
                end else begin
                    status_next      = mfs_pkg::ST_ADMITTED;
                    q_cmd.push       = advance;
                    q_cmd.push_level = in_level_reg;
                    q_cmd.push_id    = in_task_reg;
                    t_cmd.wr_en      = advance;
                    t_cmd.wr_id      = in_task_reg;
                    t_cmd.wr_time    = in_burst_reg;
                end
            end
        end else if (q_stat.nonempty == '0) begin
            status_next = mfs_pkg::ST_NO_TASK;
        end else begin
            status_next       = mfs_pkg::ST_DISPATCHED;
            task_next         = pick_id;
            served_level_next = pick_level;
            granted_next      = pick_quantum;
            q_cmd.pop         = advance;
            q_cmd.pop_level   = pick_level;
            t_cmd.wr_en       = advance;
            t_cmd.wr_id       = pick_id;
            if (fits) begin
                finished_next = 1'b1;
                t_cmd.wr_time = '0;
            end else begin
                left_next       = time_diff;
                next_level_next = down_level;
                t_cmd.wr_time   = time_diff;
                if (down_full) begin
                    dropped_next = 1'b1;
                end else begin
                    q_cmd.push       = advance;
                    q_cmd.push_level = down_level;
                    q_cmd.push_id    = pick_id;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            status_reg       <= status_next;
            task_reg         <= task_next;
            served_level_reg <= served_level_next;
            granted_reg      <= granted_next;
            left_reg         <= left_next;
            finished_reg     <= finished_next;
            next_level_reg   <= next_level_next;
            dropped_reg      <= dropped_next;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_status          = status_reg;
    assign m_served_task     = task_reg;
    assign m_served_level    = served_level_reg;
    assign m_granted_time    = granted_reg;
    assign m_time_left       = left_reg;
    assign m_finished        = finished_reg;
    assign m_next_level      = next_level_reg;
    assign m_requeue_dropped = dropped_reg;

`ifndef SYNTHESIS
    a_finish_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && finished_reg |-> left_reg == '0 && next_level_reg == '0)
        else $error("finished task reports leftover time or a requeue level");
    a_drop_only_dispatch: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && dropped_reg |->
            status_reg == mfs_pkg::ST_DISPATCHED && !finished_reg)
        else $error("requeue drop on a request that did not requeue");
    a_grant_only_dispatch: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && status_reg != mfs_pkg::ST_DISPATCHED |-> granted_reg == '0)
        else $error("time granted without a dispatch");
    a_no_bottom_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && dropped_reg |-> served_level_reg != mfs_pkg::LVL_BOTTOM)
        else $error("bottom level dropped its own requeue");
`endif

endmodule
